// ===== design/qrm_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion core
package qrm_pkg;

  localparam int FIELD_W    = 16;
  localparam int ROOT_W     = 15;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W;

  typedef struct packed {
    logic signed [FIELD_W-1:0] r00;
    logic signed [FIELD_W-1:0] r01;
    logic signed [FIELD_W-1:0] r02;
    logic signed [FIELD_W-1:0] r10;
    logic signed [FIELD_W-1:0] r11;
    logic signed [FIELD_W-1:0] r12;
    logic signed [FIELD_W-1:0] r20;
    logic signed [FIELD_W-1:0] r21;
    logic signed [FIELD_W-1:0] r22;
  } quat_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quat_w;
    logic signed [FIELD_W-1:0] quat_x;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_z;
  } quat_out_t;

endpackage

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to unit quaternion (copysign form), fixed point with FRAC_BITS fraction
// bits. One matrix is taken every clock cycle: busy stays low, and each result appears
// with out_valid high for one cycle at the end of the pipeline. The depth is set by
// the square root, which is a chain of 15 register stages producing one root bit each,
// run side by side for the four components, plus a sum stage, a radicand stage and an
// output register. The receiver cannot stall the block; results must be taken as they come.
module rotation_matrix_to_quaternion_core
  import qrm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  quat_in_t  in_data,
  output logic      out_valid,
  output quat_out_t out_data
);

  localparam int SUM_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int SHIFT  = FRAC_BITS - 2;
  localparam int N_W    = SUM_W - 1 + SHIFT;
  localparam int EXT_W  = (N_W > RAD_W + 1) ? N_W : RAD_W + 1;
  localparam int PIPE_D = ROOT_STEPS + 2;
  localparam int LAT    = PIPE_D + 1;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid and sign flags ride alongside the data
  logic [PIPE_D-1:0] vld_r;
  logic [2:0]        neg_r [PIPE_D];

  // stage 1: diagonal sums
  logic signed [SUM_W-1:0] sum_r   [4];
  logic signed [SUM_W-1:0] sum_nxt [4];
  logic [2:0]              neg_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] a00;
    logic signed [SUM_W-1:0] a11;
    logic signed [SUM_W-1:0] a22;
    logic signed [FIELD_W:0] dx;
    logic signed [FIELD_W:0] dy;
    logic signed [FIELD_W:0] dz;
    a00 = SUM_W'(in_data.r00);
    a11 = SUM_W'(in_data.r11);
    a22 = SUM_W'(in_data.r22);
    sum_nxt[0] = ONE + a00 + a11 + a22;
    sum_nxt[1] = ONE + a00 - a11 - a22;
    sum_nxt[2] = ONE - a00 + a11 - a22;
    sum_nxt[3] = ONE - a00 - a11 + a22;
    dx = (FIELD_W+1)'(in_data.r21) - (FIELD_W+1)'(in_data.r12);
    dy = (FIELD_W+1)'(in_data.r02) - (FIELD_W+1)'(in_data.r20);
    dz = (FIELD_W+1)'(in_data.r10) - (FIELD_W+1)'(in_data.r01);
    neg_nxt = {dz[FIELD_W], dy[FIELD_W], dx[FIELD_W]};
  end

  // stage 2: clamp, scale and saturation check
  logic [RAD_W-1:0] rad_r   [4];
  logic             sat_r   [4];
  logic [RAD_W-1:0] rad_nxt [4];
  logic             sat_nxt [4];

  always_comb begin
    logic [EXT_W-1:0] n_ext;
    for (int i = 0; i < 4; i++) begin
      n_ext = EXT_W'(sum_r[i][SUM_W-2:0]) << SHIFT;
      if (sum_r[i][SUM_W-1]) begin
        rad_nxt[i] = '0;
        sat_nxt[i] = 1'b0;
      end else begin
        rad_nxt[i] = n_ext[RAD_W-1:0];
        sat_nxt[i] = |n_ext[EXT_W-1:RAD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sum_r[i] <= sum_nxt[i];
      rad_r[i] <= rad_nxt[i];
      sat_r[i] <= sat_nxt[i];
    end
    neg_r[0] <= neg_nxt;
    for (int s = 1; s < PIPE_D; s++) begin
      neg_r[s] <= neg_r[s-1];
    end
  end

  // stages 3 and on: four root pipelines
  logic [ROOT_W-1:0] mag [4];

  for (genvar g = 0; g < 4; g++) begin : g_root
    qrm_sqrt_pipe u_sqrt (
      .clk   (clk),
      .rad_i (rad_r[g]),
      .sat_i (sat_r[g]),
      .mag_o (mag[g])
    );
  end

  // output register with sign applied
  quat_out_t out_nxt;
  quat_out_t out_data_r;
  logic      out_valid_r;

  function automatic logic [FIELD_W-1:0] apply_sign(input logic [ROOT_W-1:0] m,
                                                    input logic neg);
    logic [FIELD_W-1:0] v;
    v = FIELD_W'(m);
    return neg ? (FIELD_W'(0) - v) : v;
  endfunction

  always_comb begin
    out_nxt.quat_w = FIELD_W'(mag[0]);
    out_nxt.quat_x = apply_sign(mag[1], neg_r[PIPE_D-1][0]);
    out_nxt.quat_y = apply_sign(mag[2], neg_r[PIPE_D-1][1]);
    out_nxt.quat_z = apply_sign(mag[3], neg_r[PIPE_D-1][2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[PIPE_D-2:0], accept};
      out_valid_r <= vld_r[PIPE_D-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.quat_w[FIELD_W-1])
    else $error("quat_w negative");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching input beat");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_x != {1'b1, {(FIELD_W-1){1'b0}}}) &&
                  (out_data.quat_y != {1'b1, {(FIELD_W-1){1'b0}}}) &&
                  (out_data.quat_z != {1'b1, {(FIELD_W-1){1'b0}}}))
    else $error("magnitude out of range");
`endif

endmodule

// ===== design/qrm_sqrt_pipe.sv =====
// pipelined floor square root, one result bit per register stage
module qrm_sqrt_pipe
  import qrm_pkg::*;
(
  input  logic              clk,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic              sat_i,
  output logic [ROOT_W-1:0] mag_o
);

  logic [REM_W-1:0]  rem_r   [ROOT_STEPS];
  logic [ROOT_W-1:0] root_r  [ROOT_STEPS];
  logic [RAD_W-1:0]  rad_r   [ROOT_STEPS];
  logic              sat_r   [ROOT_STEPS];
  logic [REM_W-1:0]  rem_nxt [ROOT_STEPS];
  logic [ROOT_W-1:0] root_nxt[ROOT_STEPS];
  logic [RAD_W-1:0]  rad_nxt [ROOT_STEPS];
  logic              sat_nxt [ROOT_STEPS];

  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic              sat_in;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
        sat_in  = sat_i;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        rad_in  = rad_r[k-1];
        sat_in  = sat_r[k-1];
      end
      // bring down the next two radicand bits
      cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial = {root_in, 2'b01};
      if (cur >= trial) begin
        rem_nxt[k]  = cur - trial;
        root_nxt[k] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur;
        root_nxt[k] = {root_in[ROOT_W-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_in[RAD_W-3:0], 2'b00};
      sat_nxt[k] = sat_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      rad_r[k]  <= rad_nxt[k];
      sat_r[k]  <= sat_nxt[k];
    end
  end

  assign mag_o = sat_r[ROOT_STEPS-1] ? '1 : root_r[ROOT_STEPS-1];

endmodule

// ===== tb/tb_top.sv =====
// testbench for rotation_matrix_to_quaternion_core: random and directed matrices, scoreboard check
`timescale 1ns / 1ps

module tb_top;
  import qrm_pkg::*;

  localparam int FRAC       = 14;
  localparam int MAG_LIMIT  = 32767;
  localparam int DRAIN      = 30;
  localparam int MAX_CYCLES = 200000;
  localparam int RAND_BEATS = 1500;
  localparam int CALM_FIRST = 500;
  localparam int CALM_LAST  = 800;

  // expected quaternions, predicted from each accepted matrix
  class quat_scoreboard;
    quat_out_t pending_quats[$];
    int        bad_results;

    // half of sqrt(sum), truncated, in raw units of the fixed-point format
    function automatic int half_root(int sum);
      longint unsigned rad;
      longint unsigned root;
      longint unsigned bit_w;
      if (sum <= 0) begin
        return 0;
      end
      rad   = longint'(sum) << (FRAC - 2);
      root  = 0;
      bit_w = 64'h1 << 62;
      while (bit_w > rad) bit_w >>= 2;
      while (bit_w != 0) begin
        if (rad >= root + bit_w) begin
          rad  = rad - (root + bit_w);
          root = (root >> 1) + bit_w;
        end else begin
          root >>= 1;
        end
        bit_w >>= 2;
      end
      return (root > MAG_LIMIT) ? MAG_LIMIT : int'(root);
    endfunction

    function automatic logic signed [FIELD_W-1:0] copy_sign(int mag, int diff);
      return (diff < 0) ? FIELD_W'(-mag) : FIELD_W'(mag);
    endfunction

    function automatic quat_out_t predict_quat(quat_in_t m);
      int        unit;
      int        a00, a01, a02, a10, a11, a12, a20, a21, a22;
      quat_out_t q;
      unit = 1 << FRAC;
      a00 = int'(m.r00); a01 = int'(m.r01); a02 = int'(m.r02);
      a10 = int'(m.r10); a11 = int'(m.r11); a12 = int'(m.r12);
      a20 = int'(m.r20); a21 = int'(m.r21); a22 = int'(m.r22);
      q.quat_w = FIELD_W'(half_root(unit + a00 + a11 + a22));
      q.quat_x = copy_sign(half_root(unit + a00 - a11 - a22), a21 - a12);
      q.quat_y = copy_sign(half_root(unit - a00 + a11 - a22), a02 - a20);
      q.quat_z = copy_sign(half_root(unit - a00 - a11 + a22), a10 - a01);
      return q;
    endfunction

    function void note_matrix(quat_in_t m);
      pending_quats.push_back(predict_quat(m));
    endfunction

    function void check_quat(quat_out_t got);
      quat_out_t exp_q;
      if (pending_quats.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                   got.quat_w, got.quat_x, got.quat_y, got.quat_z);
        return;
      end
      exp_q = pending_quats.pop_front();
      if (got.quat_w !== exp_q.quat_w || got.quat_x !== exp_q.quat_x ||
          got.quat_y !== exp_q.quat_y || got.quat_z !== exp_q.quat_z) begin
        bad_results++;
        if (bad_results <= 10)
          $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                   exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                   got.quat_w, got.quat_x, got.quat_y, got.quat_z);
      end
    endfunction

    function bit all_good();
      return (bad_results == 0) && (pending_quats.size() == 0);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  quat_in_t  in_data = '0;
  logic      out_valid;
  quat_out_t out_data;

  quat_scoreboard sb;
  int             cycle_count = 0;
  int             beat_idx = 0;

  rotation_matrix_to_quaternion_core #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("rotation_matrix_to_quaternion_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1) sb.check_quat(out_data);
  end

  function automatic quat_in_t make_matrix(int e0, int e1, int e2, int e3, int e4,
                                           int e5, int e6, int e7, int e8);
    quat_in_t m;
    m.r00 = FIELD_W'(e0); m.r01 = FIELD_W'(e1); m.r02 = FIELD_W'(e2);
    m.r10 = FIELD_W'(e3); m.r11 = FIELD_W'(e4); m.r12 = FIELD_W'(e5);
    m.r20 = FIELD_W'(e6); m.r21 = FIELD_W'(e7); m.r22 = FIELD_W'(e8);
    return m;
  endfunction

  // fields biased toward the edges of the range
  function automatic int raw_field();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      3:       return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      4:       return $urandom_range(0, 8) - 4;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // rotation matrix from a random quaternion, rounded to the fixed-point grid plus small noise
  function automatic quat_in_t rotation_matrix();
    real qw, qx, qy, qz, norm;
    real e[9];
    int  v[9];
    qw = real'($urandom_range(0, 2000)) - 1000.0;
    qx = real'($urandom_range(0, 2000)) - 1000.0;
    qy = real'($urandom_range(0, 2000)) - 1000.0;
    qz = real'($urandom_range(0, 2000)) - 1000.0;
    norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (norm == 0.0) begin
      qw = 1.0;
      norm = 1.0;
    end
    qw = qw / norm; qx = qx / norm; qy = qy / norm; qz = qz / norm;
    e[0] = 1.0 - 2.0 * (qy * qy + qz * qz);
    e[1] = 2.0 * (qx * qy - qz * qw);
    e[2] = 2.0 * (qx * qz + qy * qw);
    e[3] = 2.0 * (qx * qy + qz * qw);
    e[4] = 1.0 - 2.0 * (qx * qx + qz * qz);
    e[5] = 2.0 * (qy * qz - qx * qw);
    e[6] = 2.0 * (qx * qz - qy * qw);
    e[7] = 2.0 * (qy * qz + qx * qw);
    e[8] = 1.0 - 2.0 * (qx * qx + qy * qy);
    for (int i = 0; i < 9; i++) begin
      v[i] = $rtoi(e[i] * real'(1 << FRAC) + ((e[i] >= 0.0) ? 0.5 : -0.5));
      v[i] = v[i] + $urandom_range(0, 6) - 3;
      if (v[i] > 32767) v[i] = 32767;
      if (v[i] < -32768) v[i] = -32768;
    end
    return make_matrix(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endfunction

  task automatic send_matrix(input quat_in_t m);
    int gap;
    bit calm;
    calm = (beat_idx >= CALM_FIRST) && (beat_idx < CALM_LAST);
    // random idle gaps, none in the calm window, keep the idle share near nine in a hundred
    if (!calm && $urandom_range(0, 99) < 4) begin
      gap = $urandom_range(1, 4);
      start   <= 1'b0;
      in_data <= make_matrix(raw_field(), raw_field(), raw_field(), raw_field(),
                             raw_field(), raw_field(), raw_field(), raw_field(), raw_field());
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (busy);
    sb.note_matrix(m);
    beat_idx++;
  endtask

  initial begin
    localparam int P = 16384;
    quat_in_t directed[$];
    sb = new();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_matrix(P, 0, 0, 0, P, 0, 0, 0, P));
    directed.push_back(make_matrix(-P, 0, 0, 0, -P, 0, 0, 0, -P));
    // half turns about each axis
    directed.push_back(make_matrix(P, 0, 0, 0, -P, 0, 0, 0, -P));
    directed.push_back(make_matrix(-P, 0, 0, 0, P, 0, 0, 0, -P));
    directed.push_back(make_matrix(-P, 0, 0, 0, -P, 0, 0, 0, P));
    // quarter turns about z, both ways
    directed.push_back(make_matrix(0, -P, 0, P, 0, 0, 0, 0, P));
    directed.push_back(make_matrix(0, P, 0, -P, 0, 0, 0, 0, P));
    // quarter turns about x and y, negative differences
    directed.push_back(make_matrix(P, 0, 0, 0, 0, P, 0, -P, 0));
    directed.push_back(make_matrix(0, 0, -P, 0, P, 0, P, 0, 0));
    directed.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767));
    directed.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768));
    directed.push_back(make_matrix(32767, -32768, 32767, 32767, 32767, -32768,
                                   -32768, 32767, 32767));
    directed.push_back(make_matrix(32767, 32767, -32768, -32768, 32767, 32767,
                                   32767, -32768, 32767));
    directed.push_back(make_matrix(-32768, 32767, -32768, -32768, -32768, 32767,
                                   32767, -32768, -32768));
    // sum of exactly zero
    directed.push_back(make_matrix(-P, 0, 0, 0, 0, 0, 0, 0, 0));
    // negative sum with negative difference: magnitude zero, no minus zero
    directed.push_back(make_matrix(-32768, 5, 0, 0, 0, 1000, 7, 0, 0));
    directed.push_back(make_matrix(0, 300, -200, 100, -32768, -1, 50, -1, 0));
    // zero differences everywhere, mixed diagonal
    directed.push_back(make_matrix(8000, 123, -77, 123, -3000, 4444, -77, 4444, 1200));
    directed.push_back(make_matrix(-1, 1, -1, -1, -1, 1, 1, -1, -1));
    directed.push_back(make_matrix(1, -1, 1, 1, 1, -1, -1, 1, 1));

    foreach (directed[i]) send_matrix(directed[i]);

    for (int n = 0; n < RAND_BEATS; n++) begin
      if ($urandom_range(0, 99) < 60)
        send_matrix(rotation_matrix());
      else
        send_matrix(make_matrix(raw_field(), raw_field(), raw_field(), raw_field(),
                                raw_field(), raw_field(), raw_field(), raw_field(),
                                raw_field()));
    end
    start <= 1'b0;

    while (sb.pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (sb.all_good()) begin
      $display("rotation_matrix_to_quaternion_core verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/qrm_pkg.sv
design/qrm_sqrt_pipe.sv
design/rotation_matrix_to_quaternion_core.sv
tb/tb_top.sv
